// ===== rtl/ipv4_port_string_checker_macros.svh =====
// Assertion macros for the ipv4_port_string_checker checker.
// Standalone header; no dependencies.
`ifndef IPV4_PORT_STRING_CHECKER_MACROS_SVH
`define IPV4_PORT_STRING_CHECKER_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define IPV4PS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define IPV4PS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ipv4ps_pkg.sv =====
// Shared types and constants for the IPv4 address:port string checker.
// No dependencies.
`default_nettype none

package ipv4ps_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] status_t;

  // Status codes
  localparam status_t ST_VALID  = 4'd0;
  localparam status_t ST_EMPTY  = 4'd1;
  localparam status_t ST_LENGTH = 4'd2;
  localparam status_t ST_FIRST  = 4'd3;
  localparam status_t ST_SLASH  = 4'd4;
  localparam status_t ST_DOTS   = 4'd5;
  localparam status_t ST_COLONS = 4'd6;
  localparam status_t ST_ADDR   = 4'd7;
  localparam status_t ST_PORT   = 4'd8;

  // Sticky character error, 3-bit form of the codes above
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_FIRST  = 3'd3;
  localparam logic [2:0] ERR_SLASH  = 3'd4;
  localparam logic [2:0] ERR_DOTS   = 3'd5;
  localparam logic [2:0] ERR_COLONS = 3'd6;

  // Port parse phases
  localparam logic [1:0] PH_SPACE  = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Characters
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_SLASH = 8'h2F;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_COLON = 8'h3A;

  // Limits
  localparam logic [4:0]  LEN_MIN      = 5'd9;
  localparam logic [4:0]  LEN_MAX      = 5'd21;
  localparam logic [4:0]  LEN_SAT      = 5'd22;
  localparam logic [4:0]  ADDR_LEN_MAX = 5'd15;
  localparam logic [4:0]  ADDR_LEN_SAT = 5'd16;
  localparam logic [2:0]  DOT_SAT      = 3'd4;
  localparam logic [2:0]  DOT_MAX      = 3'd3;
  localparam logic [1:0]  COLON_SAT    = 2'd2;
  localparam logic [2:0]  OCTETS       = 3'd4;
  localparam logic [11:0] OCTET_MAX    = 12'd255;
  localparam logic [16:0] PORT_MAX     = 17'd65535;
  localparam logic [19:0] PORT_SAT     = 20'd65536;

  typedef struct packed {
    logic [4:0]  char_count;
    logic [2:0]  first_error;
    logic [2:0]  dot_total;
    logic [1:0]  colon_total;
    logic [8:0]  octet_value;
    logic [2:0]  octet_index;
    logic        digit_seen;
    logic        address_bad;
    logic [4:0]  address_length;
    logic [1:0]  port_phase;
    logic        port_negative;
    logic [16:0] port_value;
  } scan_state_t;

  function automatic logic is_dec(input char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_blank(input char_t c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ipv4_port_string_checker.sv =====
// Path: a zero item is held in char_r, then its status is registered with out_tvalid.
// Throughput: one item per cycle; a zero item holds off the input only while a status is stalled.
// Results: one status item per text, on the zero character only; others give nothing.
// Reset: rst_n synchronous, active low; clears the scan state and both valid flags.
// Depends on ipv4ps_pkg and ipv4ps_step.
`default_nettype none

module ipv4_port_string_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] char_in
  // result channel
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata   // [3:0] status, [7:4] zero
);

  // Input register: one character waiting for the scan stage.
  ipv4ps_pkg::char_t       char_r;
  logic                    char_v_r;

  // Scan state and its next value.
  ipv4ps_pkg::scan_state_t st_r;
  ipv4ps_pkg::scan_state_t st_nxt;
  ipv4ps_pkg::status_t     status_nxt;

  // Result register.
  ipv4ps_pkg::status_t     out_status_r;
  logic                    out_v_r;

  logic adv;        // character in char_r is consumed this cycle
  logic out_free;   // result register can take a new status

  ipv4ps_step u_step (
    .cur    (st_r),
    .ch     (char_r),
    .nxt    (st_nxt),
    .status (status_nxt)
  );

  assign out_free = !out_v_r || out_tready;
  // Ordinary characters never wait; only the end-of-text item needs the result slot.
  assign adv       = char_v_r && ((char_r != ipv4ps_pkg::CH_NUL) || out_free);
  assign in_tready = !char_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
      // all-zero state is also the leading-space port phase
      st_r          <= '0;
    end else begin
      if (in_tready) begin
        char_v_r <= in_tvalid;
      end
      if (adv) begin
        st_r <= st_nxt;
      end
      if (adv && char_r == ipv4ps_pkg::CH_NUL) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      char_r <= in_tdata;
    end
    if (adv && char_r == ipv4ps_pkg::CH_NUL) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_status_r};

endmodule

`default_nettype wire

// ===== rtl/ipv4ps_step.sv =====
// Next-state and status logic for one character of the address:port scan.
// Depends on ipv4ps_pkg.
`default_nettype none

module ipv4ps_step (
  input  ipv4ps_pkg::scan_state_t cur,
  input  ipv4ps_pkg::char_t       ch,
  output ipv4ps_pkg::scan_state_t nxt,
  output ipv4ps_pkg::status_t     status
);

  logic [3:0]  digit;
  logic [11:0] oct_v;
  logic [19:0] port_v;
  logic [2:0]  dots_inc;
  logic [1:0]  colons_inc;
  logic        ch_dec;
  logic        port_digits;

  assign digit      = ch[3:0] - ipv4ps_pkg::CH_ZERO[3:0];
  assign oct_v      = 12'(cur.octet_value) * 12'd10 + 12'(digit);
  assign port_v     = 20'(cur.port_value) * 20'd10 + 20'(digit);
  assign dots_inc   = (cur.dot_total < ipv4ps_pkg::DOT_SAT) ? cur.dot_total + 3'd1
                                                            : cur.dot_total;
  assign colons_inc = (cur.colon_total < ipv4ps_pkg::COLON_SAT) ? cur.colon_total + 2'd1
                                                                : cur.colon_total;
  assign ch_dec     = ipv4ps_pkg::is_dec(ch);

  always_comb begin
    nxt         = cur;
    status      = ipv4ps_pkg::ST_VALID;
    port_digits = 1'b0;
    if (ch != ipv4ps_pkg::CH_NUL) begin
      if (cur.char_count < ipv4ps_pkg::LEN_SAT) begin
        nxt.char_count = cur.char_count + 5'd1;
      end
      if (cur.first_error == ipv4ps_pkg::ERR_NONE) begin
        if (cur.char_count == 5'd0 && !ch_dec) begin
          nxt.first_error = ipv4ps_pkg::ERR_FIRST;
        end else if (ch == ipv4ps_pkg::CH_SLASH) begin
          nxt.first_error = ipv4ps_pkg::ERR_SLASH;
        end else if (ch == ipv4ps_pkg::CH_DOT && dots_inc > ipv4ps_pkg::DOT_MAX) begin
          nxt.dot_total   = dots_inc;
          nxt.first_error = ipv4ps_pkg::ERR_DOTS;
        end else if (ch == ipv4ps_pkg::CH_COLON) begin
          nxt.colon_total = colons_inc;
          if (colons_inc > 2'd1) begin
            nxt.first_error = ipv4ps_pkg::ERR_COLONS;
          end
        end else begin
          if (ch == ipv4ps_pkg::CH_DOT) begin
            nxt.dot_total = dots_inc;
          end
          if (cur.colon_total != 2'd0) begin
            // port: atoi-style parse
            if (cur.port_phase == ipv4ps_pkg::PH_SPACE) begin
              if (ipv4ps_pkg::is_blank(ch)) begin
                nxt.port_phase = ipv4ps_pkg::PH_SPACE;
              end else if (ch == ipv4ps_pkg::CH_PLUS || ch == ipv4ps_pkg::CH_MINUS) begin
                nxt.port_negative = (ch == ipv4ps_pkg::CH_MINUS);
                nxt.port_phase    = ipv4ps_pkg::PH_DIGITS;
              end else begin
                nxt.port_phase = ipv4ps_pkg::PH_DIGITS;
                port_digits    = 1'b1;
              end
            end else if (cur.port_phase == ipv4ps_pkg::PH_DIGITS) begin
              port_digits = 1'b1;
            end
            if (port_digits) begin
              if (ch_dec) begin
                nxt.port_value = (port_v > ipv4ps_pkg::PORT_SAT) ?
                                 ipv4ps_pkg::PORT_SAT[16:0] : port_v[16:0];
              end else begin
                nxt.port_phase = ipv4ps_pkg::PH_DONE;
              end
            end
          end else begin
            // address: dotted quad, no leading zeros
            if (cur.address_length < ipv4ps_pkg::ADDR_LEN_SAT) begin
              nxt.address_length = cur.address_length + 5'd1;
            end
            if (!cur.address_bad) begin
              if (ch_dec) begin
                if (cur.digit_seen && cur.octet_value == 9'd0) begin
                  nxt.address_bad = 1'b1;
                end else if (oct_v > ipv4ps_pkg::OCTET_MAX) begin
                  nxt.address_bad = 1'b1;
                end else begin
                  nxt.octet_value = oct_v[8:0];
                  if (!cur.digit_seen) begin
                    nxt.octet_index = cur.octet_index + 3'd1;
                    if (cur.octet_index >= ipv4ps_pkg::OCTETS) begin
                      nxt.address_bad = 1'b1;
                    end else begin
                      nxt.digit_seen = 1'b1;
                    end
                  end
                end
              end else if (ch == ipv4ps_pkg::CH_DOT && cur.digit_seen) begin
                if (cur.octet_index == ipv4ps_pkg::OCTETS) begin
                  nxt.address_bad = 1'b1;
                end else begin
                  nxt.octet_value = 9'd0;
                  nxt.digit_seen  = 1'b0;
                end
              end else begin
                nxt.address_bad = 1'b1;
              end
            end
          end
        end
      end
    end else begin
      // end of text: grade and start over
      if (cur.char_count == 5'd0) begin
        status = ipv4ps_pkg::ST_EMPTY;
      end else if (cur.char_count < ipv4ps_pkg::LEN_MIN ||
                   cur.char_count > ipv4ps_pkg::LEN_MAX) begin
        status = ipv4ps_pkg::ST_LENGTH;
      end else if (cur.first_error != ipv4ps_pkg::ERR_NONE) begin
        status = {1'b0, cur.first_error};
      end else if (cur.address_bad || cur.address_length > ipv4ps_pkg::ADDR_LEN_MAX ||
                   cur.octet_index < ipv4ps_pkg::OCTETS) begin
        status = ipv4ps_pkg::ST_ADDR;
      end else if (cur.port_negative || cur.port_value == 17'd0 ||
                   cur.port_value > ipv4ps_pkg::PORT_MAX) begin
        status = ipv4ps_pkg::ST_PORT;
      end else begin
        status = ipv4ps_pkg::ST_VALID;
      end
      nxt            = '0;
      nxt.port_phase = ipv4ps_pkg::PH_SPACE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ipv4ps_checker.sv =====
// Port-level assertions for ipv4_port_string_checker, bound to the top level.
// Depends on ipv4_port_string_checker_macros.svh.
`default_nettype none
`include "ipv4_port_string_checker_macros.svh"

module ipv4ps_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic [7:0] in_tdata,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  `IPV4PS_ASSERT_ALWAYS(a_rst_clears, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `IPV4PS_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `IPV4PS_ASSERT(a_range, clk, rst_n, out_tvalid |-> out_tdata[7:4] == 4'd0 && out_tdata[3:0] <= 4'd8, "status out of range")
  `IPV4PS_ASSERT(a_cause, clk, rst_n, $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tdata == 8'd0, 2), "result without end of text")

endmodule

bind ipv4_port_string_checker ipv4ps_checker u_ipv4ps_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
